[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the queue dispatcher core.
// Needs only a clock named clock and a synchronous reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/msqd_pkg.sv]
// Package of the queue dispatcher core: sizes, FIFO entry layout, command and
// status structs, result payload and saturating helpers. No dependencies.
package msqd_pkg;

   localparam int NUM_SERVERS = 1;
   localparam int FIFO_DEPTH  = 128;

   localparam int PTR_W   = $clog2(FIFO_DEPTH);
   localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
   localparam int SRV_W   = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
   localparam int ENTRY_W = 40;
   localparam int TICK_W  = 32;
   localparam int SVC_W   = 8;

   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic             take_item;
      logic             enqueue;
      logic             read_head;
      logic             serve;
      logic             publish;
      logic [SRV_W-1:0] srv_idx;
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_free;
   } ctrl_status_type;

   // One result item
   typedef struct packed {
      logic [3:0]  jobs_started;
      logic        arrival_dropped;
      logic [7:0]  jobs_waiting;
      logic [31:0] arrivals_count;
      logic [31:0] served_count;
      logic [31:0] total_wait;
      logic [31:0] idle_ticks_sum;
   } rsp_payload_type;

   // Saturating 32-bit add
   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? MAX32 : sum[31:0];
   endfunction

   // Saturating 32-bit increment
   function automatic logic [31:0] sat_inc32(input logic [31:0] a);
      return (a == MAX32) ? MAX32 : a + 32'd1;
   endfunction

   // Circular pointer advance
   function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

endpackage

[rtl/core/msqd_req_if.sv]
// Item channel interfaces of the queue dispatcher core: tick requests in and
// per-tick results out. Depends on msqd_pkg.
interface msqd_req_if import msqd_pkg::*;;
   logic             valid;
   logic             ready;
   logic             job_arrives;
   logic [SVC_W-1:0] job_service_ticks;

   modport source (output valid, output job_arrives, output job_service_ticks,
                   input ready);
   modport sink   (input valid, input job_arrives, input job_service_ticks,
                   output ready);
endinterface

interface msqd_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  jobs_started;
   logic        arrival_dropped;
   logic [7:0]  jobs_waiting;
   logic [31:0] arrivals_count;
   logic [31:0] served_count;
   logic [31:0] total_wait;
   logic [31:0] idle_ticks_sum;

   modport source (output valid, output jobs_started, output arrival_dropped,
                   output jobs_waiting, output arrivals_count, output served_count,
                   output total_wait, output idle_ticks_sum, input ready);
   modport sink   (input valid, input jobs_started, input arrival_dropped,
                   input jobs_waiting, input arrivals_count, input served_count,
                   input total_wait, input idle_ticks_sum, output ready);
endinterface

[rtl/core/multi_server_queue_dispatcher_core.sv]
// Multi-server queue dispatcher core, top level.
// Each request item on req_ch is one time tick: job_arrives flags a new job and
// job_service_ticks gives its service time. An arrival is stamped with the tick
// count and queued in a circular job FIFO (a RAM); a full FIFO drops it and
// flags arrival_dropped. Servers are then visited in order; an idle server
// takes the head job, books its waiting time and loads its service time.
// Exactly one result item per tick leaves on rsp_ch with the tick's started
// count, the FIFO fill and the saturating totals.
// Each tick is worked in one controller pass: take the item, enqueue and read
// the FIFO head, visit each server in order, read the head again before each
// further server, and load the result register. No new item is taken until
// the pass has ended.
// Reset (synchronous, active high) empties the FIFO and clears all counters;
// FIFO contents need no clearing. A result waits in its register while the
// receiver stalls; the next tick is taken and worked meanwhile, and only its
// hand-off waits for the register to free.
// Depends on msqd_pkg, msqd_req_if, msqd_rsp_if, msqd_ctrl, msqd_dp.
`include "assert_macros.svh"

module multi_server_queue_dispatcher_core import msqd_pkg::*; (
   input logic         clock,
   input logic         reset,
   msqd_req_if.sink    req_ch,
   msqd_rsp_if.source  rsp_ch
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   rsp_payload_type rsp_data;
   logic            rsp_valid;

   msqd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   msqd_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .job_arrives       (req_ch.job_arrives),
      .job_service_ticks (req_ch.job_service_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_data          (rsp_data)
   );

   // Result channel
   assign rsp_ch.valid           = rsp_valid;
   assign rsp_ch.jobs_started    = rsp_data.jobs_started;
   assign rsp_ch.arrival_dropped = rsp_data.arrival_dropped;
   assign rsp_ch.jobs_waiting    = rsp_data.jobs_waiting;
   assign rsp_ch.arrivals_count  = rsp_data.arrivals_count;
   assign rsp_ch.served_count    = rsp_data.served_count;
   assign rsp_ch.total_wait      = rsp_data.total_wait;
   assign rsp_ch.idle_ticks_sum  = rsp_data.idle_ticks_sum;

   // Checks
   `ASSERT_NEXT(a_no_back_to_back, req_ch.valid && req_ch.ready, !req_ch.ready, "item taken mid-tick")
   `ASSERT_NEXT(a_enq_follows_take, cmd.take_item, cmd.enqueue, "enqueue step skipped")
   `ASSERT_IMPL(a_publish_free, cmd.publish, status.out_free, "result overwritten")
   `ASSERT_IMPL(a_started_bound, rsp_ch.valid, rsp_ch.jobs_started <= 4'(NUM_SERVERS), "too many starts")

endmodule

[rtl/core/msqd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module msqd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/msqd_ctrl.sv]
// Controller of the queue dispatcher core: per-tick sequencer over enqueue,
// server visits and result hand-off. Depends on msqd_pkg.
module msqd_ctrl import msqd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ENQ  = 3'd1;
   localparam logic [2:0] ST_RD   = 3'd2;
   localparam logic [2:0] ST_EX   = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [SRV_W-1:0] srv_ff, srv_in;
   logic             last_srv;

   assign last_srv = (srv_ff == SRV_W'(NUM_SERVERS - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      srv_in   = srv_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_ENQ;
         end
         ST_ENQ: begin
            srv_in   = '0;
            state_in = ST_EX;
         end
         ST_RD: begin
            state_in = ST_EX;
         end
         ST_EX: begin
            if (last_srv) begin
               state_in = ST_DONE;
            end else begin
               srv_in   = srv_ff + SRV_W'(1);
               state_in = ST_RD;
            end
         end
         ST_DONE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         srv_ff   <= '0;
      end else begin
         state_ff <= state_in;
         srv_ff   <= srv_in;
      end
   end

   // Commands
   assign req_ready     = (state_ff == ST_IDLE);
   assign cmd.take_item = (state_ff == ST_IDLE) && req_valid;
   assign cmd.enqueue   = (state_ff == ST_ENQ);
   assign cmd.read_head = (state_ff == ST_ENQ) || (state_ff == ST_RD);
   assign cmd.serve     = (state_ff == ST_EX);
   assign cmd.publish   = (state_ff == ST_DONE) && status.out_free;
   assign cmd.srv_idx   = srv_ff;

endmodule

[rtl/core/msqd_dp.sv]
// Datapath of the queue dispatcher core: job FIFO pointers and RAM, server
// counters, saturating totals and the result register. Depends on msqd_pkg, msqd_ram.
module msqd_dp import msqd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  ctrl_cmd_type     cmd,
   output ctrl_status_type  status,
   input  logic             job_arrives,
   input  logic [SVC_W-1:0] job_service_ticks,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_payload_type  rsp_data
);

   // Latched item
   logic             arrives_ff;
   logic [SVC_W-1:0] svc_ff;

   // Queue state
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic              bypass_ff, bypass_in;

   // Servers and totals
   logic [SVC_W-1:0] rem_ff [NUM_SERVERS];
   logic [31:0]      sidle_ff [NUM_SERVERS];
   logic [SVC_W-1:0] rem_cur, rem_in;
   logic [31:0]      sidle_in;
   logic [31:0]      arr_tot_ff, arr_tot_in;
   logic [31:0]      srv_tot_ff, srv_tot_in;
   logic [31:0]      wait_tot_ff, wait_tot_in;
   logic [31:0]      idle_tot_ff, idle_tot_in;
   logic [3:0]       started_ff, started_in;
   logic             dropped_ff, dropped_in;

   // Result register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   // FIFO memory
   logic               enq_ok;
   logic [ENTRY_W-1:0] wr_entry, rd_entry, job;
   logic [TICK_W-1:0]  job_arrival;
   logic [SVC_W-1:0]   job_svc;
   logic [CNT_W+7:0]   count_ext;

   assign enq_ok   = cmd.enqueue && arrives_ff && (count_ff != CNT_W'(FIFO_DEPTH));
   assign wr_entry = {tick_ff, svc_ff};

   msqd_ram #(.WIDTH(ENTRY_W), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
      .clock   (clock),
      .wr_en   (enq_ok),
      .wr_addr (tail_ff),
      .wr_data (wr_entry),
      .rd_en   (cmd.read_head),
      .rd_addr (head_ff),
      .rd_data (rd_entry)
   );

   // Head job: the arrival of this tick if it went into an empty queue
   assign job         = bypass_ff ? wr_entry : rd_entry;
   assign job_arrival = job[ENTRY_W-1:SVC_W];
   assign job_svc     = job[SVC_W-1:0];
   assign rem_cur     = rem_ff[cmd.srv_idx];

   // Tick processing
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      tick_in     = tick_ff;
      bypass_in   = bypass_ff;
      rem_in      = rem_cur;
      sidle_in    = sidle_ff[cmd.srv_idx];
      arr_tot_in  = arr_tot_ff;
      srv_tot_in  = srv_tot_ff;
      wait_tot_in = wait_tot_ff;
      idle_tot_in = idle_tot_ff;
      started_in  = started_ff;
      dropped_in  = dropped_ff;

      if (cmd.enqueue) begin
         started_in = '0;
         dropped_in = arrives_ff && !enq_ok;
         bypass_in  = enq_ok && (count_ff == '0);
         if (enq_ok) begin
            tail_in    = next_pos(tail_ff);
            count_in   = count_ff + CNT_W'(1);
            arr_tot_in = sat_inc32(arr_tot_ff);
         end
      end

      if (cmd.read_head && !cmd.enqueue) begin
         bypass_in = 1'b0;
      end

      if (cmd.serve) begin
         priority if (rem_cur != '0) begin
            rem_in = rem_cur - SVC_W'(1);
         end else if (count_ff != '0) begin
            head_in     = next_pos(head_ff);
            count_in    = count_ff - CNT_W'(1);
            started_in  = started_ff + 4'd1;
            srv_tot_in  = sat_inc32(srv_tot_ff);
            wait_tot_in = sat_add32(wait_tot_ff, tick_ff - job_arrival);
            rem_in      = (job_svc > SVC_W'(1)) ? job_svc - SVC_W'(1) : '0;
         end else begin
            sidle_in    = sat_inc32(sidle_ff[cmd.srv_idx]);
            idle_tot_in = sat_inc32(idle_tot_ff);
         end
      end

      if (cmd.publish) begin
         tick_in = tick_ff + TICK_W'(1);
      end
   end

   // Control and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         tick_ff      <= '0;
         bypass_ff    <= 1'b0;
         arr_tot_ff   <= '0;
         srv_tot_ff   <= '0;
         wait_tot_ff  <= '0;
         idle_tot_ff  <= '0;
         started_ff   <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SERVERS; i++) begin
            rem_ff[i]   <= '0;
            sidle_ff[i] <= '0;
         end
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         tick_ff     <= tick_in;
         bypass_ff   <= bypass_in;
         arr_tot_ff  <= arr_tot_in;
         srv_tot_ff  <= srv_tot_in;
         wait_tot_ff <= wait_tot_in;
         idle_tot_ff <= idle_tot_in;
         started_ff  <= started_in;
         dropped_ff  <= dropped_in;
         if (cmd.serve) begin
            rem_ff[cmd.srv_idx]   <= rem_in;
            sidle_ff[cmd.srv_idx] <= sidle_in;
         end
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item latch and result payload
   assign count_ext = {8'd0, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         arrives_ff <= job_arrives;
         svc_ff     <= job_service_ticks;
      end
      if (cmd.publish) begin
         rsp_data_ff.jobs_started    <= started_ff;
         rsp_data_ff.arrival_dropped <= dropped_ff;
         rsp_data_ff.jobs_waiting    <= count_ext[7:0];
         rsp_data_ff.arrivals_count  <= arr_tot_ff;
         rsp_data_ff.served_count    <= srv_tot_ff;
         rsp_data_ff.total_wait      <= wait_tot_ff;
         rsp_data_ff.idle_ticks_sum  <= idle_tot_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

[bench/multi_server_queue_dispatcher_core_tb.sv]
// Self-checking bench for multi_server_queue_dispatcher_core: plans ticks, drives them
// through msqd_req_if, predicts each per-tick result and checks msqd_rsp_if against it.
// Depends on msqd_pkg, msqd_req_if, msqd_rsp_if and the core itself.
module multi_server_queue_dispatcher_core_tb import msqd_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_TICKS   = 1750;
   localparam int QUIET_TAIL     = 150;    // last ticks/results with no idling
   localparam int STALL_AT       = 400;    // results seen before the long hold-off
   localparam int STALL_CYCLES   = 150;
   localparam int MID_DRAIN_AT   = 900;    // plan index that waits for an empty pipe
   localparam int SETTLE_CYCLES  = 30;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef enum {LOAD_LIGHT, LOAD_BURST, LOAD_FLOOD, LOAD_IDLE} load_mode_type;

   typedef struct {
      logic             arrives;
      logic [SVC_W-1:0] svc;
      bit               drain_first;   // hold until every result is back
   } tick_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   msqd_req_if req_ch ();
   msqd_rsp_if rsp_ch ();

   multi_server_queue_dispatcher_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #6 clock = ~clock;

   tick_item_type   tick_plan[$];
   rsp_payload_type expected_ticks[$];

   int total_items  = 1 << 30;
   int items_taken  = 0;
   int results_seen = 0;
   int mismatches   = 0;
   int send_gap, recv_gap, stall_left, idle_cycles;
   bit stall_done;

   // Shadow of the dispatcher state
   logic [31:0]      slot_stamp [FIFO_DEPTH];
   logic [SVC_W-1:0] slot_svc   [FIFO_DEPTH];
   int               q_head, q_tail, q_fill;
   logic [31:0]      tick_now;
   logic [SVC_W-1:0] srv_left [NUM_SERVERS];
   logic [31:0]      srv_idle [NUM_SERVERS];
   logic [31:0]      arrivals_tot, served_tot, wait_tot, idle_tot;

   // run statistics for the summary
   int drops_seen = 0;
   int peak_fill  = 0;

   function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // One tick of the queue: enqueue, visit servers in order, advance the tick
   function automatic rsp_payload_type predict_tick(input logic arrives,
                                                    input logic [SVC_W-1:0] svc);
      rsp_payload_type r;
      int               started;
      logic             dropped;
      logic [31:0]      stamp;
      logic [SVC_W-1:0] job_svc;
      started = 0;
      dropped = 1'b0;
      if (arrives) begin
         if (q_fill >= FIFO_DEPTH) begin
            dropped = 1'b1;
            drops_seen++;
         end else begin
            slot_stamp[q_tail] = tick_now;
            slot_svc[q_tail]   = svc;
            q_tail             = (q_tail + 1) % FIFO_DEPTH;
            q_fill++;
            arrivals_tot       = add_clamped(arrivals_tot, 32'd1);
         end
      end
      if (q_fill > peak_fill) peak_fill = q_fill;
      for (int k = 0; k < NUM_SERVERS; k++) begin
         if (srv_left[k] != '0) begin
            srv_left[k] = srv_left[k] - 1'b1;
         end else if (q_fill > 0) begin
            stamp      = slot_stamp[q_head];
            job_svc    = slot_svc[q_head];
            q_head     = (q_head + 1) % FIFO_DEPTH;
            q_fill--;
            started++;
            served_tot = add_clamped(served_tot, 32'd1);
            wait_tot   = add_clamped(wait_tot, tick_now - stamp);
            // service of 0 or 1 frees the server for the next tick
            srv_left[k] = (job_svc > 1) ? job_svc - 1'b1 : '0;
         end else begin
            srv_idle[k] = add_clamped(srv_idle[k], 32'd1);
            idle_tot    = add_clamped(idle_tot, 32'd1);
         end
      end
      tick_now          = tick_now + 32'd1;
      r.jobs_started    = 4'(started);
      r.arrival_dropped = dropped;
      r.jobs_waiting    = 8'(q_fill);
      r.arrivals_count  = arrivals_tot;
      r.served_count    = served_tot;
      r.total_wait      = wait_tot;
      r.idle_ticks_sum  = idle_tot;
      return r;
   endfunction

   task automatic plan_tick(input logic arrives, input logic [SVC_W-1:0] svc,
                            input bit drain_first);
      tick_item_type t;
      t.arrives     = arrives;
      t.svc         = svc;
      t.drain_first = drain_first;
      tick_plan.push_back(t);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   // Driver: presents planned ticks, predicts each one as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid             <= 1'b0;
         req_ch.job_arrives       <= 1'b0;
         req_ch.job_service_ticks <= '0;
         send_gap                 <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_ticks.push_back(predict_tick(req_ch.job_arrives,
                                                  req_ch.job_service_ticks));
            items_taken <= items_taken + 1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap     <= send_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (total_items - items_taken > QUIET_TAIL &&
                         $urandom_range(0, 9) == 0) begin
               send_gap     <= $urandom_range(0, 2);
               req_ch.valid <= 1'b0;
            end else if (tick_plan.size() > 0 &&
                         !(tick_plan[0].drain_first && expected_ticks.size() > 0)) begin
               req_ch.valid             <= 1'b1;
               req_ch.job_arrives       <= tick_plan[0].arrives;
               req_ch.job_service_ticks <= tick_plan[0].svc;
               void'(tick_plan.pop_front());
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result against the oldest prediction, bursts of back-pressure
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap     <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen <= results_seen + 1;
            if (expected_ticks.size() == 0) begin
               $error("result item with no tick outstanding");
               mismatches++;
            end else begin
               want = expected_ticks.pop_front();
               check_field("jobs_started", 32'(want.jobs_started),
                           32'(rsp_ch.jobs_started));
               check_field("arrival_dropped", 32'(want.arrival_dropped),
                           32'(rsp_ch.arrival_dropped));
               check_field("jobs_waiting", 32'(want.jobs_waiting),
                           32'(rsp_ch.jobs_waiting));
               check_field("arrivals_count",  want.arrivals_count,  rsp_ch.arrivals_count);
               check_field("served_count",    want.served_count,    rsp_ch.served_count);
               check_field("total_wait",      want.total_wait,      rsp_ch.total_wait);
               check_field("idle_ticks_sum",  want.idle_ticks_sum,  rsp_ch.idle_ticks_sum);
            end
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap     <= recv_gap - 1;
            rsp_ch.ready <= 1'b0;
         end else if (total_items - results_seen > QUIET_TAIL &&
                      $urandom_range(0, 7) == 0) begin
            recv_gap     <= $urandom_range(0, 2);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // One long hold-off on the result side so the core backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         stall_done <= 1'b0;
      end else if (!stall_done && results_seen == STALL_AT) begin
         stall_left <= STALL_CYCLES;
         stall_done <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // Watchdog: too long without any handshake on either side
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", idle_cycles);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      load_mode_type mode;
      int            seg_len;
      int            directed_n;
      logic          arr;

      req_ch.valid             = 1'b0;
      req_ch.job_arrives       = 1'b0;
      req_ch.job_service_ticks = '0;
      rsp_ch.ready             = 1'b0;

      q_head       = 0;
      q_tail       = 0;
      q_fill       = 0;
      tick_now     = '0;
      arrivals_tot = '0;
      served_tot   = '0;
      wait_tot     = '0;
      idle_tot     = '0;
      for (int k = 0; k < NUM_SERVERS; k++) begin
         srv_left[k] = '0;
         srv_idle[k] = '0;
      end

      // Directed: idle ticks with junk service, shortest/zero/longest jobs, queueing
      plan_tick(1'b0, 8'h00, 1'b0);
      plan_tick(1'b0, 8'hFF, 1'b0);
      plan_tick(1'b1, 8'h01, 1'b0);
      plan_tick(1'b1, 8'h00, 1'b0);
      plan_tick(1'b0, 8'h5A, 1'b0);
      plan_tick(1'b1, 8'hFF, 1'b0);
      plan_tick(1'b1, 8'h02, 1'b0);
      plan_tick(1'b1, 8'h80, 1'b0);
      plan_tick(1'b1, 8'h7F, 1'b0);
      plan_tick(1'b0, 8'hA5, 1'b0);
      plan_tick(1'b1, 8'h00, 1'b0);
      plan_tick(1'b0, 8'h00, 1'b0);
      plan_tick(1'b1, 8'h03, 1'b0);
      plan_tick(1'b0, 8'h01, 1'b0);
      plan_tick(1'b1, 8'hAA, 1'b1);    // sender pauses until the pipe is empty
      plan_tick(1'b1, 8'h55, 1'b0);
      directed_n = tick_plan.size();

      // Random: segments of different load, the first one overflowing the queue
      mode = LOAD_FLOOD;
      while (tick_plan.size() < directed_n + RANDOM_TICKS) begin
         seg_len = $urandom_range(20, 60);
         case (mode)
            LOAD_FLOOD: begin
               // long job blocks the server while arrivals fill and overflow the queue
               plan_tick(1'b1, 8'hFF, 1'b0);
               for (int i = 0; i < FIFO_DEPTH + 12; i++)
                  plan_tick(1'b1, 8'($urandom_range(0, 3)), 1'b0);
            end
            LOAD_BURST: begin
               for (int i = 0; i < seg_len; i++) begin
                  arr = ($urandom_range(0, 9) < 7);
                  plan_tick(arr, ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                             : 8'($urandom_range(0, 3)), 1'b0);
               end
            end
            LOAD_LIGHT: begin
               for (int i = 0; i < seg_len; i++) begin
                  arr = ($urandom_range(0, 9) < 3);
                  plan_tick(arr, arr ? 8'($urandom_range(0, 5)) : 8'($urandom_range(0, 255)),
                            1'b0);
               end
            end
            default: begin
               for (int i = 0; i < seg_len; i++)
                  plan_tick(1'b0, 8'($urandom_range(0, 255)), 1'b0);
            end
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3: mode = LOAD_LIGHT;
            4, 5, 6:    mode = LOAD_BURST;
            7, 8:       mode = LOAD_IDLE;
            default:    mode = LOAD_FLOOD;
         endcase
      end
      tick_plan[MID_DRAIN_AT].drain_first = 1'b1;
      total_items = tick_plan.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (items_taken < total_items || expected_ticks.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d ticks checked: %0d arrivals queued, %0d dropped on a full queue",
               results_seen, arrivals_tot, drops_seen);
      $display("%0d jobs started, deepest queue %0d, %0d field mismatches",
               served_tot, peak_fill, mismatches);
      if (mismatches == 0 && expected_ticks.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
